@@ design/tnf_pkg.sv @@
// Shared types, constants and character helpers for the text normalize filter.
// No dependencies; imported by tnf_datapath, tnf_ctrl and the top level.
package tnf_pkg;

  localparam int MODE_W = 9;

  localparam int MODE_DROP_ALL  = 0;
  localparam int MODE_DROP_LEAD = 1;
  localparam int MODE_DROP_TAIL = 2;
  localparam int MODE_COLLAPSE  = 3;
  localparam int MODE_QUOTES    = 4;
  localparam int MODE_UPPER     = 5;
  localparam int MODE_LOWER     = 6;
  localparam int MODE_DROP_CTL  = 7;
  localparam int MODE_TOGGLE    = 8;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FRD,
    S_FWR,
    S_ORD,
    S_OWR,
    S_LAST
  } ctl_state_t;

  typedef enum logic [2:0] {
    DEC_DROP,
    DEC_TERM,
    DEC_HOLD,
    DEC_OVF,
    DEC_EMIT,
    DEC_FLUSH
  } dec_t;

  typedef enum logic [1:0] {
    SRC_DIRECT,
    SRC_HELD,
    SRC_PEND
  } out_src_t;

  typedef struct packed {
    logic     accept;
    logic     out_load;
    out_src_t out_src;
    logic     out_last;
    logic     out_ovf;
    logic     pop;
    logic     rotate;
  } cmd_t;

  typedef struct packed {
    dec_t dec;
    logic out_free;
    logic held_one;
    logic held_empty;
    logic held_full;
  } sts_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_control(input logic [7:0] c);
    return (c < CH_SPACE) || (c == CH_DEL);
  endfunction

  function automatic logic [7:0] case_map(input logic [7:0] c,
                                          input logic [MODE_W-1:0] mode);
    logic [7:0] r;
    r = c;
    if (c < 8'h80) begin
      if (mode[MODE_UPPER] && r >= "a" && r <= "z") r = r - CASE_BIT;
      if (mode[MODE_LOWER] && r >= "A" && r <= "Z") r = r + CASE_BIT;
      if (mode[MODE_TOGGLE]) begin
        if (r >= "a" && r <= "z") r = r - CASE_BIT;
        else if (r >= "A" && r <= "Z") r = r + CASE_BIT;
      end
    end
    return r;
  endfunction

endpackage

@@ design/tnf_in_if.sv @@
// Input channel: valid/ready handshake carrying one text byte per beat.
// No dependencies.
interface tnf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

@@ design/tnf_out_if.sv @@
// Result channel: valid/ready handshake carrying one filtered byte and flags per beat.
// No dependencies.
interface tnf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_string;
  logic       held_overflow;
  logic       last;

  modport source (output valid, output out_byte, output end_of_string,
                  output held_overflow, output last, input ready);
  modport sink   (input valid, input out_byte, input end_of_string,
                  input held_overflow, input last, output ready);
endinterface

@@ design/tnf_datapath.sv @@
// Datapath: mode register, string flags, byte classification, held-white store
// (circular memory) and the result register. Depends on tnf_pkg.
module tnf_datapath import tnf_pkg::*; #(
  parameter int HELD_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata,
  input  logic [7:0]        in_byte,
  input  logic              out_ready,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_eos,
  output logic              out_ovf,
  output logic              out_last
);

  localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CW = $clog2(HELD_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(HELD_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(HELD_DEPTH);
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(HELD_DEPTH);

  logic [MODE_W-1:0] mode_r;
  logic              quote_active_r, quote_active_nxt;
  logic [7:0]        quote_opener_r, quote_opener_nxt;
  logic              white_run_r, white_run_nxt;
  logic              seen_nonwhite_r, seen_nonwhite_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [7:0]        pend_r;
  logic [7:0]        rd_data_r;
  logic [7:0]        mem [HELD_DEPTH];

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_eos_r, out_ovf_r, out_last_r;

  logic              send_en, term;
  logic [7:0]        send_byte;
  logic              collapse;
  dec_t              dec;
  logic [AW:0]       tail_sum;
  logic [AW-1:0]     tail_idx, head_inc;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic              out_free;

  // classify the incoming byte and work out the string flags it leaves
  always_comb begin
    send_en           = 1'b0;
    term              = 1'b0;
    send_byte         = in_byte;
    quote_active_nxt  = quote_active_r;
    quote_opener_nxt  = quote_opener_r;
    white_run_nxt     = white_run_r;
    seen_nonwhite_nxt = seen_nonwhite_r;
    collapse          = !mode_r[MODE_DROP_ALL] && mode_r[MODE_COLLAPSE];
    if (in_byte == CH_NUL) begin
      term              = 1'b1;
      quote_active_nxt  = 1'b0;
      quote_opener_nxt  = CH_NUL;
      white_run_nxt     = 1'b0;
      seen_nonwhite_nxt = 1'b0;
    end else if (quote_active_r) begin
      send_en = 1'b1;
      if (in_byte == quote_opener_r) quote_active_nxt = 1'b0;
    end else if (mode_r[MODE_QUOTES] && (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE)) begin
      send_en           = 1'b1;
      white_run_nxt     = 1'b0;
      seen_nonwhite_nxt = 1'b1;
      quote_active_nxt  = 1'b1;
      quote_opener_nxt  = in_byte;
    end else if (is_white(in_byte)) begin
      if (mode_r[MODE_DROP_ALL]) begin
        send_en = 1'b0;
      end else if (mode_r[MODE_DROP_LEAD] && !seen_nonwhite_r) begin
        send_en = 1'b0;
      end else if (collapse) begin
        if (!white_run_r) begin
          send_en       = 1'b1;
          send_byte     = CH_SPACE;
          white_run_nxt = 1'b1;
        end
      end else if (mode_r[MODE_DROP_CTL] && in_byte != CH_SPACE) begin
        send_en = 1'b0;
      end else begin
        send_en = 1'b1;
      end
    end else if (is_control(in_byte)) begin
      white_run_nxt     = 1'b0;
      seen_nonwhite_nxt = 1'b1;
      send_en           = !mode_r[MODE_DROP_CTL];
    end else begin
      white_run_nxt     = 1'b0;
      seen_nonwhite_nxt = 1'b1;
      send_en           = 1'b1;
      send_byte         = case_map(in_byte, mode_r);
    end

    if (term) begin
      dec = DEC_TERM;
    end else if (!send_en) begin
      dec = DEC_DROP;
    end else if (is_white(send_byte) && mode_r[MODE_DROP_TAIL]) begin
      dec = (count_r == FULL_CNT) ? DEC_OVF : DEC_HOLD;
    end else begin
      dec = (count_r == '0) ? DEC_EMIT : DEC_FLUSH;
    end
  end

  assign tail_sum = {1'b0, head_r} + (AW+1)'(count_r);
  assign tail_idx = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : tail_sum[AW-1:0];
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    mem_we    = 1'b0;
    mem_waddr = tail_idx;
    mem_wdata = send_byte;
    if (cmd.accept && dec == DEC_TERM) begin
      count_nxt = '0;
    end else if (cmd.accept && dec == DEC_HOLD) begin
      mem_we    = 1'b1;
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - 1'b1;
    end else if (cmd.rotate) begin
      // full store: oldest slot is reused by the pending byte
      mem_we    = 1'b1;
      mem_waddr = head_r;
      mem_wdata = pend_r;
      head_nxt  = head_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[head_r];
  end

  assign out_free      = !out_valid_r || out_ready;
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= '0;
      quote_active_r  <= 1'b0;
      quote_opener_r  <= CH_NUL;
      white_run_r     <= 1'b0;
      seen_nonwhite_r <= 1'b0;
      head_r          <= '0;
      count_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      if (cmd.accept) begin
        quote_active_r  <= quote_active_nxt;
        quote_opener_r  <= quote_opener_nxt;
        white_run_r     <= white_run_nxt;
        seen_nonwhite_r <= seen_nonwhite_nxt;
      end
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) pend_r <= send_byte;
    if (cmd.out_load) begin
      out_ovf_r  <= cmd.out_ovf;
      out_last_r <= cmd.out_last;
      case (cmd.out_src)
        SRC_DIRECT: begin
          out_byte_r <= send_byte;
          out_eos_r  <= term;
        end
        SRC_HELD: begin
          out_byte_r <= rd_data_r;
          out_eos_r  <= 1'b0;
        end
        SRC_PEND: begin
          out_byte_r <= pend_r;
          out_eos_r  <= 1'b0;
        end
        default: begin
          out_byte_r <= pend_r;
          out_eos_r  <= 1'b0;
        end
      endcase
    end
  end

  assign sts.dec        = dec;
  assign sts.out_free   = out_free;
  assign sts.held_one   = (count_r == CW'(1));
  assign sts.held_empty = (count_r == '0);
  assign sts.held_full  = (count_r == FULL_CNT);

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_eos   = out_eos_r;
  assign out_ovf   = out_ovf_r;
  assign out_last  = out_last_r;

endmodule

@@ design/tnf_ctrl.sv @@
// Controller: sequences acceptance, store flushes and overflow release.
// Depends on tnf_pkg; drives commands into tnf_datapath.
module tnf_ctrl import tnf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.out_load = 1'b0;
    cmd.out_src  = SRC_DIRECT;
    cmd.out_last = 1'b0;
    cmd.out_ovf  = 1'b0;
    cmd.pop      = 1'b0;
    cmd.rotate   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
        if (cmd.accept) begin
          case (sts.dec)
            DEC_TERM, DEC_EMIT: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
            end
            DEC_FLUSH: state_nxt = S_FRD;
            DEC_OVF:   state_nxt = S_ORD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_FRD: state_nxt = S_FWR;
      S_FWR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_HELD;
          cmd.pop      = 1'b1;
          state_nxt    = sts.held_one ? S_LAST : S_FRD;
        end
      end
      S_ORD: state_nxt = S_OWR;
      S_OWR: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_HELD;
          cmd.out_ovf  = 1'b1;
          cmd.out_last = 1'b1;
          cmd.rotate   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_LAST: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_PEND;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ design/text_normalize_filter_core.sv @@
// Text normalize filter top level: channel interfaces, controller and datapath.
// Depends on tnf_pkg, tnf_in_if, tnf_out_if, tnf_ctrl and tnf_datapath.
//
// Streaming text filter: one byte per input beat, zero or more result beats per byte,
// the final one marked by last. A byte that is dropped or held, or that is emitted
// while the held-white store is empty, leaves the controller idle, so such bytes
// stream at one per cycle when the result side keeps up. A byte that flushes N held
// white bytes follows them; each is one read of the store memory and then a load of
// the result register. A byte that overflows a full store causes a read of the oldest
// entry, then release and rewrite of that slot. The user must write mode through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// The store needs no clearing after reset; its fill count starts at zero.
module text_normalize_filter_core import tnf_pkg::*; #(
  parameter int HELD_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata,
  tnf_in_if.sink            in_ch,
  tnf_out_if.source         out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  tnf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tnf_datapath #(
    .HELD_DEPTH (HELD_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_ch.text_byte),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_byte  (out_ch.out_byte),
    .out_eos   (out_ch.end_of_string),
    .out_ovf   (out_ch.held_overflow),
    .out_last  (out_ch.last)
  );

  assign in_ch.ready = in_ready;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register loaded while a beat is pending");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !sts.held_empty)
    else $error("held store popped while empty");

  a_rotate_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rotate |-> sts.held_full)
    else $error("overflow release without a full store");

  a_term_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.dec == DEC_TERM) |=>
      (out_ch.valid && out_ch.end_of_string && out_ch.last && out_ch.out_byte == CH_NUL))
    else $error("terminator beat missing after string end");

endmodule
